@@ sv/phrc_pkg.sv @@
// ============================================================================
// PS/2 host reply classifier package
// Shared types, codes and field layout for the reply classifier and its checker.
// ============================================================================
package phrc_pkg;

   // Largest number of response bytes a command may expect.
   localparam int RESPONSE_MAX = 15;

   // Field widths of the request and response transfers.
   localparam int REQ_DATA_W = 56;
   localparam int REQ_USER_W = 2;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USER_W = 4;
   localparam int CSR_ADDR_W = 1;
   localparam int CSR_DATA_W = 32;

   // Configuration register indexes.
   localparam logic [CSR_ADDR_W-1:0] CSR_PORT_IS_KEYBOARD  = 1'b0;
   localparam logic [CSR_ADDR_W-1:0] CSR_HOTPLUG_WINDOW_US = 1'b1;

   localparam logic [31:0] HOTPLUG_WINDOW_RESET = 32'd50000;

   // Protocol bytes.
   localparam logic [7:0] BYTE_ACK        = 8'hFA;
   localparam logic [7:0] BYTE_NACK       = 8'hFE;
   localparam logic [7:0] BYTE_NACK_ERR   = 8'hFC;
   localparam logic [7:0] BYTE_GET_ID     = 8'hF2;
   localparam logic [7:0] BYTE_REMOVAL    = 8'hFD;
   localparam logic [7:0] BYTE_SELF_TEST  = 8'hAA;
   localparam logic [7:0] BYTE_ZERO       = 8'h00;
   localparam logic [7:0] BYTE_ID_WHEEL   = 8'h03;
   localparam logic [7:0] BYTE_ID_5BUTTON = 8'h04;

   // Request function codes.
   typedef enum logic [1:0] {
      FUNC_ARM     = 2'd0,
      FUNC_RX_BYTE = 2'd1,
      FUNC_ABORT   = 2'd2,
      FUNC_FINISH  = 2'd3
   } func_type;

   // Response verdict codes.
   typedef enum logic [3:0] {
      VERDICT_CONTROL       = 4'd0,
      VERDICT_ACK           = 4'd1,
      VERDICT_NACK          = 4'd2,
      VERDICT_IDACK         = 4'd3,
      VERDICT_STORED        = 4'd4,
      VERDICT_COMPLETE      = 4'd5,
      VERDICT_REMOVAL       = 4'd6,
      VERDICT_PLUG          = 4'd7,
      VERDICT_REPUBLISH     = 4'd8,
      VERDICT_MAYBE_PLUG    = 4'd9,
      VERDICT_DROP_INACTIVE = 4'd10,
      VERDICT_DROP_DISABLED = 4'd11,
      VERDICT_PASS          = 4'd12
   } verdict_type;

   // One request item as held in the input register.
   typedef struct packed {
      func_type    func;
      logic [7:0]  tx_byte;
      logic        is_first_byte;
      logic [3:0]  response_count;
      logic [7:0]  rx_byte;
      logic        rx_error;
      logic [31:0] rx_time_us;
      logic        device_active;
      logic        device_enabled;
   } req_item_type;

   // One response item as held in the output register.
   typedef struct packed {
      verdict_type verdict;
      logic [1:0]  wake_count;
      logic [7:0]  response_byte;
      logic [3:0]  response_index;
      logic [3:0]  missing_count;
      logic        ack_flag;
      logic        nack_flag;
      logic        command_busy;
   } rsp_item_type;

endpackage

@@ sv/ps2_host_reply_classifier_top.sv @@
// ============================================================================
// PS/2 host reply classifier
// Classifies host arm, abort and finish events and device bytes for one port.
// ============================================================================
//
// Usage:
// The request channel (req_*) carries one event per transfer: req_tuser holds
// the function code, req_tdata the transmitted byte, command fields, received
// byte, error flag, arrival time and device status. Every request transfer
// yields exactly one response transfer on the rsp_* channel, whose tuser holds
// the verdict and whose tdata holds the wake count, stored response byte and
// index, missing count and the ack, nack and busy flags after the event.
// The csr_* port writes the keyboard flag and the hot plug window; write it
// only while no transfer is in flight.
// A request reaches response valid through one input register and one result
// register. Throughput is one item per cycle while the response side takes
// every transfer; the single pass of classification logic on the command state
// sets that figure. A full result register that is not taken stalls the input
// register, and the request side then stalls in turn. Reset clears the command
// state, the previous byte and time, restores the configuration defaults and
// empties both registers.
// ============================================================================
module ps2_host_reply_classifier_top (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   // From bit 0: tx_byte[7:0], is_first_byte, response_count[3:0], rx_byte[7:0],
   // rx_error, rx_time_us[31:0], device_active, device_enabled.
   input  logic [phrc_pkg::REQ_DATA_W-1:0]     req_tdata,
   // From bit 0: func[1:0].
   input  logic [phrc_pkg::REQ_USER_W-1:0]     req_tuser,
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // From bit 0: wake_count[1:0], response_byte[7:0], response_index[3:0],
   // missing_count[3:0], ack_flag, nack_flag, command_busy, three zero bits.
   output logic [phrc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   // From bit 0: verdict[3:0].
   output logic [phrc_pkg::RSP_USER_W-1:0]     rsp_tuser,
   // Configuration write port.
   input  logic                                csr_we,
   input  logic [phrc_pkg::CSR_ADDR_W-1:0]     csr_addr,
   input  logic [phrc_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   // Pipeline registers.
   logic                   in_valid_ff, in_valid_in;
   phrc_pkg::req_item_type in_item_ff, in_item_in;
   logic                   out_valid_ff, out_valid_in;
   phrc_pkg::rsp_item_type out_item_ff, out_item_in;

   // Configuration registers.
   logic        port_is_keyboard_ff, port_is_keyboard_in;
   logic [31:0] hotplug_window_ff, hotplug_window_in;

   // Command state.
   logic        command_open_ff, command_open_in;
   logic        ack_seen_ff, ack_seen_in;
   logic        nack_seen_ff, nack_seen_in;
   logic        getid_mode_ff, getid_mode_in;
   logic [3:0]  remaining_ff, remaining_in;
   logic [3:0]  write_index_ff, write_index_in;
   logic [7:0]  previous_byte_ff, previous_byte_in;
   logic [31:0] previous_time_ff, previous_time_in;

   logic req_accept;
   logic advance;

   // Handshake: the input register moves into the result register when the
   // result register is empty or is being drained in this cycle.
   assign advance    = in_valid_ff & (~out_valid_ff | rsp_tready);
   assign req_tready = ~in_valid_ff | advance;
   assign req_accept = req_tvalid & req_tready;

   // Unpack the request transfer.
   always_comb begin
      in_item_in.func           = phrc_pkg::func_type'(req_tuser[1:0]);
      in_item_in.tx_byte        = req_tdata[7:0];
      in_item_in.is_first_byte  = req_tdata[8];
      in_item_in.response_count = req_tdata[12:9];
      in_item_in.rx_byte        = req_tdata[20:13];
      in_item_in.rx_error       = req_tdata[21];
      in_item_in.rx_time_us     = req_tdata[53:22];
      in_item_in.device_active  = req_tdata[54];
      in_item_in.device_enabled = req_tdata[55];
   end

   // Valid bits of the two registers.
   always_comb begin
      in_valid_in = in_valid_ff;
      if (req_accept) begin
         in_valid_in = 1'b1;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end
      out_valid_in = out_valid_ff;
      if (advance) begin
         out_valid_in = 1'b1;
      end else if (rsp_tready) begin
         out_valid_in = 1'b0;
      end
   end

   // Configuration writes.
   always_comb begin
      port_is_keyboard_in = port_is_keyboard_ff;
      hotplug_window_in   = hotplug_window_ff;
      if (csr_we) begin
         case (csr_addr)
            phrc_pkg::CSR_PORT_IS_KEYBOARD:  port_is_keyboard_in = csr_wdata[0];
            phrc_pkg::CSR_HOTPLUG_WINDOW_US: hotplug_window_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   // Classification of the item in the input register.
   logic        rx_is_ack, rx_is_nack, rx_is_id, take_byte, passed;
   logic        in_window;
   logic [31:0] gap;
   logic [7:0]  count_wide;
   logic [3:0]  count_sat;
   logic [3:0]  remaining_dec;
   phrc_pkg::verdict_type pass_verdict;

   always_comb begin
      rx_is_ack  = in_item_ff.rx_byte == phrc_pkg::BYTE_ACK;
      rx_is_nack = (in_item_ff.rx_byte == phrc_pkg::BYTE_NACK) ||
                   (in_item_ff.rx_byte == phrc_pkg::BYTE_NACK_ERR);
      rx_is_id   = (in_item_ff.rx_byte == phrc_pkg::BYTE_ZERO) ||
                   (in_item_ff.rx_byte == phrc_pkg::BYTE_ID_WHEEL) ||
                   (in_item_ff.rx_byte == phrc_pkg::BYTE_ID_5BUTTON);
      gap        = in_item_ff.rx_time_us - previous_time_ff;
      in_window  = gap < hotplug_window_ff;
      remaining_dec = remaining_ff - 4'd1;

      // Expected count, saturated to the response buffer size.
      count_wide = {4'd0, in_item_ff.response_count};
      count_sat  = (count_wide > 8'(phrc_pkg::RESPONSE_MAX)) ?
                   4'(phrc_pkg::RESPONSE_MAX) : in_item_ff.response_count;

      // Bytes not taken by a command: hot plug detection and filtering.
      if (!port_is_keyboard_ff && in_item_ff.rx_error &&
          in_item_ff.rx_byte == phrc_pkg::BYTE_REMOVAL) begin
         pass_verdict = phrc_pkg::VERDICT_REMOVAL;
      end else if (!port_is_keyboard_ff && in_item_ff.rx_byte == phrc_pkg::BYTE_ZERO &&
                   previous_byte_ff == phrc_pkg::BYTE_SELF_TEST && in_window) begin
         pass_verdict = in_item_ff.device_active ? phrc_pkg::VERDICT_REPUBLISH :
                                                   phrc_pkg::VERDICT_PLUG;
      end else if (!in_item_ff.device_active) begin
         pass_verdict = (in_item_ff.rx_byte != phrc_pkg::BYTE_ZERO &&
                         in_item_ff.rx_byte != phrc_pkg::BYTE_SELF_TEST) ?
                        phrc_pkg::VERDICT_MAYBE_PLUG : phrc_pkg::VERDICT_DROP_INACTIVE;
      end else if (!in_item_ff.device_enabled) begin
         pass_verdict = phrc_pkg::VERDICT_DROP_DISABLED;
      end else begin
         pass_verdict = phrc_pkg::VERDICT_PASS;
      end

      command_open_in  = command_open_ff;
      ack_seen_in      = ack_seen_ff;
      nack_seen_in     = nack_seen_ff;
      getid_mode_in    = getid_mode_ff;
      remaining_in     = remaining_ff;
      write_index_in   = write_index_ff;
      previous_byte_in = previous_byte_ff;
      previous_time_in = previous_time_ff;
      take_byte        = 1'b0;
      passed           = 1'b0;

      out_item_in.verdict        = phrc_pkg::VERDICT_CONTROL;
      out_item_in.wake_count     = 2'd0;
      out_item_in.response_byte  = 8'd0;
      out_item_in.response_index = 4'd0;
      out_item_in.missing_count  = 4'd0;

      case (in_item_ff.func)
         phrc_pkg::FUNC_ARM: begin
            ack_seen_in   = 1'b0;
            nack_seen_in  = 1'b0;
            getid_mode_in = 1'b0;
            if (in_item_ff.is_first_byte) begin
               remaining_in    = count_sat;
               write_index_in  = 4'd0;
               command_open_in = 1'b1;
               getid_mode_in   = in_item_ff.tx_byte == phrc_pkg::BYTE_GET_ID;
            end
         end
         phrc_pkg::FUNC_ABORT: begin
            command_open_in = 1'b0;
         end
         phrc_pkg::FUNC_FINISH: begin
            command_open_in           = 1'b0;
            out_item_in.missing_count = remaining_ff;
            remaining_in              = 4'd0;
         end
         phrc_pkg::FUNC_RX_BYTE: begin
            if (!command_open_ff) begin
               passed = 1'b1;
            end else if (!ack_seen_ff && !nack_seen_ff) begin
               if (rx_is_ack) begin
                  ack_seen_in            = 1'b1;
                  out_item_in.verdict    = phrc_pkg::VERDICT_ACK;
                  out_item_in.wake_count = 2'd1;
               end else if (rx_is_nack) begin
                  nack_seen_in           = 1'b1;
                  out_item_in.verdict    = phrc_pkg::VERDICT_NACK;
                  out_item_in.wake_count = 2'd1;
               end else if (getid_mode_ff && rx_is_id) begin
                  // A mouse answered get-id with its id instead of an ack.
                  ack_seen_in            = 1'b1;
                  out_item_in.verdict    = phrc_pkg::VERDICT_IDACK;
                  out_item_in.wake_count = 2'd1;
                  if (remaining_ff != 4'd0) begin
                     take_byte = 1'b1;
                     if (remaining_dec == 4'd0) begin
                        command_open_in        = 1'b0;
                        out_item_in.wake_count = 2'd2;
                     end
                  end
               end else begin
                  passed = 1'b1;
               end
            end else if (remaining_ff != 4'd0) begin
               take_byte           = 1'b1;
               out_item_in.verdict = phrc_pkg::VERDICT_STORED;
               if (remaining_dec == 4'd0) begin
                  command_open_in        = 1'b0;
                  out_item_in.verdict    = phrc_pkg::VERDICT_COMPLETE;
                  out_item_in.wake_count = 2'd1;
               end
            end else begin
               passed = 1'b1;
            end
            if (passed) begin
               out_item_in.verdict = pass_verdict;
            end
            previous_byte_in = in_item_ff.rx_byte;
            previous_time_in = in_item_ff.rx_time_us;
         end
         default: ;
      endcase

      // Store a response byte at the current write position.
      if (take_byte) begin
         out_item_in.response_byte  = in_item_ff.rx_byte;
         out_item_in.response_index = write_index_ff;
         write_index_in             = write_index_ff + 4'd1;
         remaining_in               = remaining_dec;
      end

      out_item_in.ack_flag     = ack_seen_in;
      out_item_in.nack_flag    = nack_seen_in;
      out_item_in.command_busy = command_open_in;
   end

   // Control and state registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff         <= 1'b0;
         out_valid_ff        <= 1'b0;
         port_is_keyboard_ff <= 1'b0;
         hotplug_window_ff   <= phrc_pkg::HOTPLUG_WINDOW_RESET;
         command_open_ff     <= 1'b0;
         ack_seen_ff         <= 1'b0;
         nack_seen_ff        <= 1'b0;
         getid_mode_ff       <= 1'b0;
         remaining_ff        <= 4'd0;
         write_index_ff      <= 4'd0;
         previous_byte_ff    <= 8'd0;
         previous_time_ff    <= 32'd0;
      end else begin
         in_valid_ff         <= in_valid_in;
         out_valid_ff        <= out_valid_in;
         port_is_keyboard_ff <= port_is_keyboard_in;
         hotplug_window_ff   <= hotplug_window_in;
         if (advance) begin
            command_open_ff  <= command_open_in;
            ack_seen_ff      <= ack_seen_in;
            nack_seen_ff     <= nack_seen_in;
            getid_mode_ff    <= getid_mode_in;
            remaining_ff     <= remaining_in;
            write_index_ff   <= write_index_in;
            previous_byte_ff <= previous_byte_in;
            previous_time_ff <= previous_time_in;
         end
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         in_item_ff <= in_item_in;
      end
      if (advance) begin
         out_item_ff <= out_item_in;
      end
   end

   // Pack the response transfer.
   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser  = out_item_ff.verdict;
   assign rsp_tdata  = {3'd0,
                        out_item_ff.command_busy,
                        out_item_ff.nack_flag,
                        out_item_ff.ack_flag,
                        out_item_ff.missing_count,
                        out_item_ff.response_index,
                        out_item_ff.response_byte,
                        out_item_ff.wake_count};

endmodule

@@ sv/phrc_checker.sv @@
// ============================================================================
// PS/2 host reply classifier checker
// Port-level assertions on the response channel, bound to the top level.
// ============================================================================
module phrc_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                rsp_tvalid,
   input logic                                rsp_tready,
   input logic [phrc_pkg::RSP_DATA_W-1:0]     rsp_tdata,
   input logic [phrc_pkg::RSP_USER_W-1:0]     rsp_tuser
);

   logic [1:0] wake_count;
   logic [3:0] missing_count;
   logic       ack_flag, nack_flag, command_busy;

   assign wake_count    = rsp_tdata[1:0];
   assign missing_count = rsp_tdata[17:14];
   assign ack_flag      = rsp_tdata[18];
   assign nack_flag     = rsp_tdata[19];
   assign command_busy  = rsp_tdata[20];

   // The response register is empty after reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response transfer keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // Two wakeups only come from a get-id answer that closes the command.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && wake_count == 2'd2 |->
         rsp_tuser == phrc_pkg::VERDICT_IDACK && !command_busy)
      else $error("double wakeup without closing get-id answer");

   // A missing count is reported only by a control item.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && missing_count != 4'd0 |-> rsp_tuser == phrc_pkg::VERDICT_CONTROL)
      else $error("missing count on a non-control verdict");

   // A transmitted byte is never both acked and nacked.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(ack_flag && nack_flag))
      else $error("ack and nack flags both set");

endmodule

bind ps2_host_reply_classifier_top phrc_checker u_phrc_checker (.*);

@@ tb/sv/tb_ps2_host_reply_classifier_top.sv @@
`timescale 1ns / 100ps
// ============================================================================
// PS/2 host reply classifier testbench
// Drives arm, received-byte, abort and finish events through the request
// stream, predicts each verdict and the command state after it, and compares
// every response transfer field by field. A short directed part covers the
// command flow, nacks, the get-id workaround and the hot plug paths. Random
// command sequences and plug pairs then follow under several port settings,
// with bursty requests and a stalling response side.
// ============================================================================
module tb_ps2_host_reply_classifier_top;

   localparam int CLOCK_PERIOD = 4;
   localparam int RESET_CYCLES = 11;
   localparam int IDLE_LIMIT   = 2000;
   localparam int RANDOM_ITEMS = 1950;
   localparam int PHASES       = 8;
   localparam int DRAIN_CYCLES = 8;

   // Response-side stall patterns.
   localparam int STALL_NONE        = 0;
   localparam int STALL_RANDOM      = 1;
   localparam int STALL_EVERY_THIRD = 2;
   localparam int STALL_LONG        = 3;

   logic                            clock      = 1'b0;
   logic                            reset      = 1'b1;
   logic                            req_tvalid = 1'b0;
   logic                            req_tready;
   logic [phrc_pkg::REQ_DATA_W-1:0] req_tdata  = '0;
   logic [phrc_pkg::REQ_USER_W-1:0] req_tuser  = '0;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [phrc_pkg::RSP_DATA_W-1:0] rsp_tdata;
   logic [phrc_pkg::RSP_USER_W-1:0] rsp_tuser;
   logic                            csr_we     = 1'b0;
   logic [phrc_pkg::CSR_ADDR_W-1:0] csr_addr   = '0;
   logic [phrc_pkg::CSR_DATA_W-1:0] csr_wdata  = '0;

   // Predicted port configuration and command state.
   logic        cfg_keyboard = 1'b0;
   logic [31:0] cfg_window   = phrc_pkg::HOTPLUG_WINDOW_RESET;
   logic        cmd_open     = 1'b0;
   logic        acked        = 1'b0;
   logic        nacked       = 1'b0;
   logic        getid        = 1'b0;
   logic [3:0]  remaining    = '0;
   logic [3:0]  wr_idx       = '0;
   logic [7:0]  last_rx_byte = '0;
   logic [31:0] last_rx_time = '0;

   phrc_pkg::rsp_item_type expected_replies[$];

   int unsigned items_sent    = 0;
   int unsigned replies_seen  = 0;
   int unsigned mismatches    = 0;
   int unsigned idle_cycles   = 0;
   int          burst_left    = 0;
   int          stall_mode    = STALL_NONE;
   int          mode_left     = 0;
   int unsigned stall_phase   = 0;
   logic [31:0] clock_us      = '0;

   ps2_host_reply_classifier_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_we     (csr_we),
      .csr_addr   (csr_addr),
      .csr_wdata  (csr_wdata)
   );

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // Store one response byte at the write position and count it off.
   function automatic void take_response_byte(input logic [7:0] b,
                                              inout phrc_pkg::rsp_item_type e);
      e.response_byte = b;
      e.response_index = wr_idx;
      wr_idx = wr_idx + 4'd1;
      remaining = remaining - 4'd1;
   endfunction

   // Classify one event and advance the predicted command state.
   function automatic phrc_pkg::rsp_item_type classify_reply(input phrc_pkg::req_item_type r);
      phrc_pkg::rsp_item_type e;
      logic                   unclaimed;
      logic [31:0]            gap_us;
      e = '0;
      e.verdict = phrc_pkg::VERDICT_CONTROL;
      unclaimed = 1'b0;
      case (r.func)
         phrc_pkg::FUNC_ARM: begin
            acked = 1'b0;
            nacked = 1'b0;
            getid = 1'b0;
            if (r.is_first_byte) begin
               remaining = (int'(r.response_count) > phrc_pkg::RESPONSE_MAX) ?
                           4'(phrc_pkg::RESPONSE_MAX) : r.response_count;
               wr_idx = '0;
               cmd_open = 1'b1;
               getid = (r.tx_byte == phrc_pkg::BYTE_GET_ID);
            end
         end
         phrc_pkg::FUNC_ABORT: begin
            cmd_open = 1'b0;
         end
         phrc_pkg::FUNC_FINISH: begin
            cmd_open = 1'b0;
            e.missing_count = remaining;
            remaining = '0;
         end
         default: begin
            if (!cmd_open) begin
               unclaimed = 1'b1;
            end else if (!acked && !nacked) begin
               if (r.rx_byte == phrc_pkg::BYTE_ACK) begin
                  acked = 1'b1;
                  e.verdict = phrc_pkg::VERDICT_ACK;
                  e.wake_count = 2'd1;
               end else if (r.rx_byte == phrc_pkg::BYTE_NACK ||
                            r.rx_byte == phrc_pkg::BYTE_NACK_ERR) begin
                  nacked = 1'b1;
                  e.verdict = phrc_pkg::VERDICT_NACK;
                  e.wake_count = 2'd1;
               end else if (getid && (r.rx_byte == phrc_pkg::BYTE_ZERO ||
                                      r.rx_byte == phrc_pkg::BYTE_ID_WHEEL ||
                                      r.rx_byte == phrc_pkg::BYTE_ID_5BUTTON)) begin
                  // A mouse that answers get-id with its id instead of an ack.
                  acked = 1'b1;
                  e.verdict = phrc_pkg::VERDICT_IDACK;
                  e.wake_count = 2'd1;
                  if (remaining != 0) begin
                     take_response_byte(r.rx_byte, e);
                     if (remaining == 0) begin
                        cmd_open = 1'b0;
                        e.wake_count = 2'd2;
                     end
                  end
               end else begin
                  unclaimed = 1'b1;
               end
            end else if (remaining != 0) begin
               take_response_byte(r.rx_byte, e);
               e.verdict = phrc_pkg::VERDICT_STORED;
               if (remaining == 0) begin
                  cmd_open = 1'b0;
                  e.verdict = phrc_pkg::VERDICT_COMPLETE;
                  e.wake_count = 2'd1;
               end
            end else begin
               unclaimed = 1'b1;
            end
            // Bytes no command takes: removal and plug detection, then drop or pass.
            if (unclaimed) begin
               gap_us = r.rx_time_us - last_rx_time;
               if (!cfg_keyboard && r.rx_error && r.rx_byte == phrc_pkg::BYTE_REMOVAL) begin
                  e.verdict = phrc_pkg::VERDICT_REMOVAL;
               end else if (!cfg_keyboard && r.rx_byte == phrc_pkg::BYTE_ZERO &&
                            last_rx_byte == phrc_pkg::BYTE_SELF_TEST &&
                            gap_us < cfg_window) begin
                  e.verdict = r.device_active ? phrc_pkg::VERDICT_REPUBLISH :
                                                phrc_pkg::VERDICT_PLUG;
               end else if (!r.device_active) begin
                  e.verdict = (r.rx_byte != phrc_pkg::BYTE_ZERO &&
                               r.rx_byte != phrc_pkg::BYTE_SELF_TEST) ?
                              phrc_pkg::VERDICT_MAYBE_PLUG :
                              phrc_pkg::VERDICT_DROP_INACTIVE;
               end else if (!r.device_enabled) begin
                  e.verdict = phrc_pkg::VERDICT_DROP_DISABLED;
               end else begin
                  e.verdict = phrc_pkg::VERDICT_PASS;
               end
            end
            last_rx_byte = r.rx_byte;
            last_rx_time = r.rx_time_us;
         end
      endcase
      e.ack_flag = acked;
      e.nack_flag = nacked;
      e.command_busy = cmd_open;
      return e;
   endfunction

   // Random content in every field; builders below override what matters.
   function automatic phrc_pkg::req_item_type random_event();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return phrc_pkg::req_item_type'(bits[$bits(phrc_pkg::req_item_type)-1:0]);
   endfunction

   function automatic phrc_pkg::req_item_type arm_event(input logic [7:0] tx,
                                                        input logic first,
                                                        input logic [3:0] count);
      phrc_pkg::req_item_type r;
      r = random_event();
      r.func = phrc_pkg::FUNC_ARM;
      r.tx_byte = tx;
      r.is_first_byte = first;
      r.response_count = count;
      return r;
   endfunction

   function automatic phrc_pkg::req_item_type rx_event(input logic [7:0] b, input logic err,
                                                       input logic [31:0] t,
                                                       input logic active,
                                                       input logic enabled);
      phrc_pkg::req_item_type r;
      r = random_event();
      r.func = phrc_pkg::FUNC_RX_BYTE;
      r.rx_byte = b;
      r.rx_error = err;
      r.rx_time_us = t;
      r.device_active = active;
      r.device_enabled = enabled;
      return r;
   endfunction

   function automatic phrc_pkg::req_item_type control_event(input phrc_pkg::func_type f);
      phrc_pkg::req_item_type r;
      r = random_event();
      r.func = f;
      return r;
   endfunction

   // Received bytes lean toward the protocol bytes the classifier looks for.
   function automatic logic [7:0] pick_rx_byte();
      logic [7:0] special [9];
      special = '{phrc_pkg::BYTE_ACK, phrc_pkg::BYTE_NACK, phrc_pkg::BYTE_NACK_ERR,
                  phrc_pkg::BYTE_GET_ID, phrc_pkg::BYTE_REMOVAL, phrc_pkg::BYTE_SELF_TEST,
                  phrc_pkg::BYTE_ZERO, phrc_pkg::BYTE_ID_WHEEL, phrc_pkg::BYTE_ID_5BUTTON};
      if ($urandom_range(0, 99) < 35) return special[$urandom_range(0, 8)];
      return 8'($urandom);
   endfunction

   // Arrival times mostly move forward; now and then the counter jumps anywhere.
   function automatic logic [31:0] next_time();
      if ($urandom_range(0, 19) == 0) clock_us = $urandom;
      else clock_us = clock_us + 32'($urandom_range(1, 70000));
      return clock_us;
   endfunction

   task automatic report_mismatch(input string what, input int unsigned got,
                                  input int unsigned want);
      $display("mismatch on reply %0d at %0t: %s got %0d, expected %0d",
               replies_seen, $time, what, got, want);
      mismatches++;
   endtask

   task automatic check_reply(input logic [phrc_pkg::RSP_DATA_W-1:0] d,
                              input logic [phrc_pkg::RSP_USER_W-1:0] u);
      phrc_pkg::rsp_item_type e;
      replies_seen++;
      if (expected_replies.size() == 0) begin
         report_mismatch("transfer with nothing expected, verdict", u, 0);
         return;
      end
      e = expected_replies.pop_front();
      if (u[3:0] !== e.verdict) report_mismatch("verdict", u[3:0], e.verdict);
      if (d[1:0] !== e.wake_count) report_mismatch("wake_count", d[1:0], e.wake_count);
      if (d[9:2] !== e.response_byte)
         report_mismatch("response_byte", d[9:2], e.response_byte);
      if (d[13:10] !== e.response_index)
         report_mismatch("response_index", d[13:10], e.response_index);
      if (d[17:14] !== e.missing_count)
         report_mismatch("missing_count", d[17:14], e.missing_count);
      if (d[18] !== e.ack_flag) report_mismatch("ack_flag", d[18], e.ack_flag);
      if (d[19] !== e.nack_flag) report_mismatch("nack_flag", d[19], e.nack_flag);
      if (d[20] !== e.command_busy) report_mismatch("command_busy", d[20], e.command_busy);
      if (d[23:21] !== 3'b000) report_mismatch("pad bits", d[23:21], 0);
   endtask

   // Send one event; the sender runs in bursts with random gaps between them.
   task automatic send_request(input phrc_pkg::req_item_type r);
      int gap;
      req_tvalid <= 1'b1;
      req_tuser <= r.func;
      req_tdata <= {r.device_enabled, r.device_active, r.rx_time_us, r.rx_error,
                    r.rx_byte, r.response_count, r.is_first_byte, r.tx_byte};
      do @(posedge clock); while (!req_tready);
      expected_replies.push_back(classify_reply(r));
      items_sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(0, 10);
         if ($urandom_range(0, 9) == 0) burst_left = $urandom_range(32, 96);
         else burst_left = $urandom_range(0, 12);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
   endtask

   // Port settings change only once every reply is back and the pipeline is empty.
   task automatic configure_port(input logic keyboard, input logic [31:0] window);
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      csr_we <= 1'b1;
      csr_addr <= phrc_pkg::CSR_PORT_IS_KEYBOARD;
      csr_wdata <= {31'b0, keyboard};
      @(posedge clock);
      csr_addr <= phrc_pkg::CSR_HOTPLUG_WINDOW_US;
      csr_wdata <= window;
      @(posedge clock);
      csr_we <= 1'b0;
      cfg_keyboard = keyboard;
      cfg_window = window;
   endtask

   // Command with ack, one stored byte, completion and a clean finish.
   task automatic test_ack_and_responses();
      send_request(arm_event(8'hE9, 1'b1, 4'd2));
      send_request(rx_event(phrc_pkg::BYTE_ACK, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(rx_event(8'h11, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(rx_event(8'h22, 1'b1, next_time(), 1'b0, 1'b0));
      send_request(control_event(phrc_pkg::FUNC_FINISH));
   endtask

   // Both nack bytes, a re-arm that is not a first byte, abort keeping the count.
   task automatic test_nack_and_abort();
      send_request(arm_event(8'hFF, 1'b1, 4'd2));
      send_request(rx_event(phrc_pkg::BYTE_NACK, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(arm_event(8'h00, 1'b0, 4'd15));
      send_request(rx_event(phrc_pkg::BYTE_NACK_ERR, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(control_event(phrc_pkg::FUNC_ABORT));
      send_request(control_event(phrc_pkg::FUNC_FINISH));
   endtask

   // Get-id answered by an id: with no room, with the last slot, with the largest count.
   task automatic test_getid_workaround();
      send_request(arm_event(phrc_pkg::BYTE_GET_ID, 1'b1, 4'd0));
      send_request(rx_event(phrc_pkg::BYTE_ZERO, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(control_event(phrc_pkg::FUNC_FINISH));
      send_request(arm_event(phrc_pkg::BYTE_GET_ID, 1'b1, 4'd1));
      send_request(rx_event(phrc_pkg::BYTE_ID_5BUTTON, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(arm_event(phrc_pkg::BYTE_GET_ID, 1'b1, 4'd15));
      send_request(rx_event(phrc_pkg::BYTE_ID_WHEEL, 1'b0, next_time(), 1'b1, 1'b1));
      send_request(control_event(phrc_pkg::FUNC_ABORT));
   endtask

   // Bytes outside a command: removal, plug, republish across the time wrap, drops.
   task automatic test_unclaimed_bytes();
      send_request(rx_event(phrc_pkg::BYTE_REMOVAL, 1'b1, 32'd500, 1'b1, 1'b1));
      send_request(rx_event(phrc_pkg::BYTE_SELF_TEST, 1'b0, 32'd1000, 1'b1, 1'b1));
      send_request(rx_event(phrc_pkg::BYTE_ZERO, 1'b0, 32'd50999, 1'b0, 1'b1));
      send_request(rx_event(phrc_pkg::BYTE_SELF_TEST, 1'b0, 32'hFFFF_FFF0, 1'b1, 1'b0));
      send_request(rx_event(phrc_pkg::BYTE_ZERO, 1'b0, 32'h0000_0010, 1'b1, 1'b1));
      send_request(rx_event(8'h55, 1'b0, next_time(), 1'b0, 1'b1));
      send_request(rx_event(phrc_pkg::BYTE_SELF_TEST, 1'b0, next_time(), 1'b0, 1'b0));
   endtask

   // A well-formed command with random content and a random ending.
   task automatic run_command_sequence();
      phrc_pkg::req_item_type r;
      logic [7:0]             b;
      int                     n;
      int                     kind;
      r = arm_event(($urandom_range(0, 2) == 0) ? phrc_pkg::BYTE_GET_ID : 8'($urandom),
                    1'b1, 4'($urandom_range(0, 15)));
      send_request(r);
      if ($urandom_range(0, 9) == 0)
         send_request(arm_event(8'($urandom), 1'b0, 4'($urandom)));
      kind = $urandom_range(0, 99);
      if (kind < 55) begin
         b = phrc_pkg::BYTE_ACK;
      end else if (kind < 70) begin
         b = $urandom_range(0, 1) ? phrc_pkg::BYTE_NACK : phrc_pkg::BYTE_NACK_ERR;
      end else if (kind < 85) begin
         case ($urandom_range(0, 2))
            0: b = phrc_pkg::BYTE_ZERO;
            1: b = phrc_pkg::BYTE_ID_WHEEL;
            default: b = phrc_pkg::BYTE_ID_5BUTTON;
         endcase
      end else begin
         b = pick_rx_byte();
      end
      send_request(rx_event(b, 1'($urandom), next_time(), 1'($urandom), 1'($urandom)));
      if ($urandom_range(0, 3) == 0) n = $urandom_range(0, int'(r.response_count));
      else n = int'(r.response_count) + $urandom_range(0, 1);
      repeat (n)
         send_request(rx_event(pick_rx_byte(), 1'($urandom), next_time(), 1'($urandom),
                               1'($urandom)));
      kind = $urandom_range(0, 9);
      if (kind < 5) send_request(control_event(phrc_pkg::FUNC_FINISH));
      else if (kind < 8) send_request(control_event(phrc_pkg::FUNC_ABORT));
   endtask

   // Self-test then zero with a gap around the plug window, sometimes a removal.
   task automatic run_plug_sequence();
      logic [31:0] t0;
      logic [31:0] delta;
      t0 = next_time();
      send_request(rx_event(phrc_pkg::BYTE_SELF_TEST, 1'($urandom_range(0, 7) == 0), t0,
                            1'($urandom), 1'($urandom)));
      case ($urandom_range(0, 4))
         0: delta = cfg_window - 32'd1;
         1: delta = cfg_window;
         2: delta = cfg_window + 32'd1;
         3: delta = 32'($urandom_range(0, 99999));
         default: delta = $urandom;
      endcase
      clock_us = t0 + delta;
      send_request(rx_event(($urandom_range(0, 7) == 0) ? pick_rx_byte() : phrc_pkg::BYTE_ZERO,
                            1'($urandom), clock_us, 1'($urandom), 1'($urandom)));
      if ($urandom_range(0, 3) == 0)
         send_request(rx_event(phrc_pkg::BYTE_REMOVAL, 1'($urandom_range(0, 3) != 0),
                               next_time(), 1'($urandom), 1'($urandom)));
   endtask

   // Random traffic under a series of port settings, window extremes included.
   task automatic test_random_traffic();
      phrc_pkg::req_item_type r;
      logic                   keyboard;
      logic [31:0]            window;
      int unsigned            phase_end;
      int                     pick;
      for (int phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin keyboard = 1'b0; window = phrc_pkg::HOTPLUG_WINDOW_RESET; end
            1: begin keyboard = 1'b1; window = phrc_pkg::HOTPLUG_WINDOW_RESET; end
            2: begin keyboard = 1'b0; window = 32'd0; end
            3: begin keyboard = 1'b0; window = 32'hFFFF_FFFF; end
            4: begin keyboard = 1'b1; window = 32'd0; end
            5: begin keyboard = 1'b0; window = 32'd1; end
            6: begin keyboard = 1'b0; window = $urandom; end
            default: begin keyboard = 1'b1; window = $urandom; end
         endcase
         configure_port(keyboard, window);
         phase_end = items_sent + RANDOM_ITEMS / PHASES;
         while (items_sent < phase_end) begin
            pick = $urandom_range(0, 99);
            if (pick < 60) begin
               run_command_sequence();
            end else if (pick < 85) begin
               run_plug_sequence();
            end else begin
               // Noise: any function with any content.
               r = random_event();
               if (r.func == phrc_pkg::FUNC_RX_BYTE) begin
                  r.rx_byte = pick_rx_byte();
                  if ($urandom_range(0, 1)) r.rx_time_us = next_time();
               end
               send_request(r);
            end
         end
      end
   endtask

   // Response side: check each transfer, then pick readiness from the stall pattern.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) check_reply(rsp_tdata, rsp_tuser);
         if (mode_left == 0) begin
            stall_mode = $urandom_range(STALL_NONE, STALL_LONG);
            mode_left = $urandom_range(64, 256);
         end else begin
            mode_left--;
         end
         stall_phase++;
         case (stall_mode)
            STALL_NONE: rsp_tready <= 1'b1;
            STALL_RANDOM: rsp_tready <= ($urandom_range(0, 3) != 0);
            STALL_EVERY_THIRD: rsp_tready <= ((stall_phase % 3) == 0);
            default: rsp_tready <= ((stall_phase % 8) >= 5);
         endcase
      end
   end

   // Watchdog on cycles in which neither side moves a transfer.
   always @(posedge clock) begin
      if (!reset) begin
         if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) idle_cycles = 0;
         else idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("FAILURE");
            $finish;
         end
      end
   end

   initial begin
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      configure_port(1'b0, phrc_pkg::HOTPLUG_WINDOW_RESET);
      test_ack_and_responses();
      test_nack_and_abort();
      test_getid_workaround();
      test_unclaimed_bytes();
      test_random_traffic();
      req_tvalid <= 1'b0;
      while (expected_replies.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule

@@ ps2_host_reply_classifier_top.f @@
sv/phrc_pkg.sv
sv/ps2_host_reply_classifier_top.sv
sv/phrc_checker.sv
tb/sv/tb_ps2_host_reply_classifier_top.sv
